>>> sv/srt_pkg.sv
`default_nettype none

package srt_pkg;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF    = 256;
	localparam int ID_WIDTH_DEF = 64;

	// Fixed width of the slot number fields
	localparam int IDX_W = 10;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] status_t;

	// Operation codes
	localparam opcode_t OP_REGISTER   = 2'd0;
	localparam opcode_t OP_UNREGISTER = 2'd1;
	localparam opcode_t OP_LOOKUP     = 2'd2;

	// Response status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_TAKEN = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_MISS  = 2'd3;

endpackage

`default_nettype wire

>>> sv/srt_req_if.sv
`default_nettype none

interface srt_req_if import srt_pkg::*; #(
	parameter int ID_WIDTH = ID_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	opcode_t             opcode;
	logic                index_given;
	logic [IDX_W-1:0]    slot_index;
	logic [ID_WIDTH-1:0] object_id;

	modport source (output valid, opcode, index_given, slot_index, object_id, input ready);
	modport sink   (input valid, opcode, index_given, slot_index, object_id, output ready);
endinterface

`default_nettype wire

>>> sv/srt_rsp_if.sv
`default_nettype none

interface srt_rsp_if import srt_pkg::*; #(
	parameter int ID_WIDTH = ID_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	status_t             status;
	logic [IDX_W-1:0]    result_index;
	logic                found;
	logic [ID_WIDTH-1:0] result_id;

	modport source (output valid, status, result_index, found, result_id, input ready);
	modport sink   (input valid, status, result_index, found, result_id, output ready);
endinterface

`default_nettype wire

>>> sv/srt_ram.sv
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port
module srt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/srt_ctrl.sv
`default_nettype none

// Sequencer: valid bits, insert hint, forward scan and response register.
// The id table sits in an external RAM read at accept and written at commit.
module srt_ctrl import srt_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int ID_WIDTH = ID_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int HW = $clog2(DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	srt_req_if.sink                  req,
	srt_rsp_if.source                rsp,
	output logic                     ram_we,
	output logic      [AW-1:0]       ram_waddr,
	output logic      [ID_WIDTH-1:0] ram_wdata,
	output logic                     ram_re,
	output logic      [AW-1:0]       ram_raddr,
	input  wire logic [ID_WIDTH-1:0] ram_rdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	localparam logic [IDX_W:0] DEPTH_X   = (IDX_W + 1)'(DEPTH);
	localparam logic [HW-1:0]  HINT_END  = HW'(DEPTH);

	logic [1:0]          state_q;
	opcode_t             op_q;
	logic                given_q;
	logic [IDX_W-1:0]    idx_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [HW-1:0]       hint_q;
	logic [DEPTH-1:0]    valid_q;

	logic                out_valid_q;
	status_t             status_q;
	logic [IDX_W-1:0]    rindex_q;
	logic                found_q;
	logic [ID_WIDTH-1:0] rid_q;

	logic                accept;
	logic                commit;
	logic                idx_in_range;
	logic [AW-1:0]       idx_slot;
	logic [AW-1:0]       hint_slot;
	logic                hint_end;
	logic                slot_hit;

	status_t             status_d;
	logic [IDX_W-1:0]    rindex_d;
	logic                found_d;
	logic [ID_WIDTH-1:0] rid_d;
	logic                set_v;
	logic                clr_v;
	logic                hint_adv;
	logic [AW-1:0]       wr_slot;

	assign req.ready    = (state_q == S_IDLE);
	assign accept       = req.valid && req.ready;
	assign commit       = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);

	assign idx_in_range = {1'b0, idx_q} < DEPTH_X;
	assign idx_slot     = idx_q[AW-1:0];
	assign hint_end     = (hint_q == HINT_END);
	assign hint_slot    = hint_q[AW-1:0];
	assign slot_hit     = idx_in_range && valid_q[idx_slot];

	// RAM: read the requested slot at accept, write back at commit
	assign ram_re    = accept;
	assign ram_raddr = req.slot_index[AW-1:0];
	assign ram_we    = commit && set_v;
	assign ram_waddr = wr_slot;
	assign ram_wdata = id_q;

	// Result and state changes of the held transaction
	always_comb begin
		status_d = ST_MISS;
		rindex_d = idx_q;
		found_d  = 1'b0;
		rid_d    = '0;
		set_v    = 1'b0;
		clr_v    = 1'b0;
		hint_adv = 1'b0;
		wr_slot  = idx_slot;
		case (op_q)
			OP_REGISTER: begin
				if (given_q) begin
					if (!idx_in_range) begin
						status_d = ST_MISS;
					end else if (valid_q[idx_slot]) begin
						status_d = ST_TAKEN;
					end else begin
						status_d = ST_OK;
						set_v    = 1'b1;
					end
				end else begin
					if (hint_end) begin
						status_d = ST_FULL;
						rindex_d = '0;
					end else begin
						status_d = ST_OK;
						rindex_d = IDX_W'(hint_q);
						set_v    = 1'b1;
						hint_adv = 1'b1;
						wr_slot  = hint_slot;
					end
				end
			end
			OP_UNREGISTER: begin
				if (slot_hit) begin
					status_d = ST_OK;
					clr_v    = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (slot_hit) begin
					status_d = ST_OK;
					found_d  = 1'b1;
					rid_d    = ram_rdata;
				end
			end
			default: begin
				status_d = ST_MISS;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.opcode == OP_REGISTER && !req.index_given) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_SCAN: begin
					if (hint_end || !valid_q[hint_slot]) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Captured request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.opcode;
			given_q <= req.index_given;
			idx_q   <= req.slot_index;
			id_q    <= req.object_id;
		end
	end

	// Insert hint: walks past taken slots, one per cycle, never moves back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q <= '0;
		end else if (state_q == S_SCAN && !hint_end && valid_q[hint_slot]) begin
			hint_q <= hint_q + 1'b1;
		end else if (commit && hint_adv) begin
			hint_q <= hint_q + 1'b1;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (commit) begin
			if (set_v) begin
				valid_q[wr_slot] <= 1'b1;
			end
			if (clr_v) begin
				valid_q[idx_slot] <= 1'b0;
			end
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			rindex_q <= rindex_d;
			found_q  <= found_d;
			rid_q    <= rid_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.result_index = rindex_q;
	assign rsp.found        = found_q;
	assign rsp.result_id    = rid_q;

	a_hint_forward: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> hint_q >= $past(hint_q))
		else $error("insert hint moved back");

	a_hint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= HINT_END)
		else $error("insert hint past the end of the table");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(ram_waddr)])
		else $error("id written without its valid bit");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> status_q == ST_OK)
		else $error("found flag with a failing status");

endmodule

`default_nettype wire

>>> sv/slot_registrar_table.sv
// Channel  Modport  Transaction
// -------  -------  ----------------------------------------------------------
// req      sink     opcode, index_given, slot_index, object_id
// rsp      source   status, result_index, found, result_id
//
// Unregister, lookup and register at a given slot go from accept, with the id RAM
// read, to the commit state. An allocating register first passes the scan state,
// where the insert hint walks past taken slots, one per cycle, then commits.
// Reset clears the valid bits, the insert hint and the control state; the id RAM
// is not cleared. A held response does not block accepting the next request;
// the commit cycle waits until the response register is free.
`default_nettype none

module slot_registrar_table import srt_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int ID_WIDTH = ID_WIDTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	srt_req_if.sink   req,
	srt_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [ID_WIDTH-1:0] ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [ID_WIDTH-1:0] ram_rdata;

	srt_ctrl #(
		.DEPTH    (DEPTH),
		.ID_WIDTH (ID_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Object id table
	srt_ram #(
		.WIDTH (ID_WIDTH),
		.DEPTH (DEPTH)
	) u_id_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

>>> bench/slot_registrar_table_tb.sv
`timescale 1ns / 1ps

module slot_registrar_table_tb;
	import srt_pkg::*;

	localparam int DEPTH    = DEPTH_DEF;
	localparam int ID_WIDTH = ID_WIDTH_DEF;

	// Opcode three has no meaning and must come back as a miss
	localparam opcode_t OP_UNUSED = 2'd3;

	localparam int          LIMIT_CYCLES = 1_500_000;
	localparam int          SETTLE_CYCLES = DEPTH + 40;
	localparam int          HOLD_CYCLES = 400;
	localparam logic [7:0]  STALL_PAT = 8'b1101_0110;

	localparam logic [ID_WIDTH-1:0] ID_ZERO = '0;
	localparam logic [ID_WIDTH-1:0] ID_ONES = '1;
	localparam logic [ID_WIDTH-1:0] ID_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [ID_WIDTH-1:0] ID_ALT_5 = 64'h5555_5555_5555_5555;
	localparam logic [ID_WIDTH-1:0] ID_RAMP_UP = 64'h0123_4567_89AB_CDEF;
	localparam logic [ID_WIDTH-1:0] ID_RAMP_DN = 64'hFEDC_BA98_7654_3210;

	typedef struct packed {
		opcode_t             op;
		logic                given;
		logic [IDX_W-1:0]    idx;
		logic [ID_WIDTH-1:0] id;
	} request_t;

	typedef struct packed {
		status_t             status;
		logic [IDX_W-1:0]    idx;
		logic                found;
		logic [ID_WIDTH-1:0] id;
	} reply_t;

	typedef struct {
		opcode_t             op;
		logic                given;
		logic [IDX_W-1:0]    idx;
		logic [ID_WIDTH-1:0] id;
		bit                  typed;
		status_t             w_status;
		logic [IDX_W-1:0]    w_idx;
		logic                w_found;
		logic [ID_WIDTH-1:0] w_id;
	} plan_row_t;

	// Directed opening; typed rows carry their own answer, the rest go to the predictor
	plan_row_t plan [$] = '{
		// after reset: nothing stored, nothing to free
		'{OP_LOOKUP,     1'b0, 10'd1023, ID_ZERO,    1'b1, ST_MISS,  10'd1023, 1'b0, ID_ZERO},
		'{OP_UNREGISTER, 1'b0, 10'd0,    ID_ZERO,    1'b1, ST_MISS,  10'd0,    1'b0, ID_ZERO},
		'{OP_REGISTER,   1'b0, 10'd0,    ID_ONES,    1'b1, ST_OK,    10'd0,    1'b0, ID_ZERO},
		'{OP_LOOKUP,     1'b0, 10'd0,    ID_ZERO,    1'b1, ST_OK,    10'd0,    1'b1, ID_ONES},
		// last slot, taken slot, out of range
		'{OP_REGISTER,   1'b1, 10'd255,  ID_ZERO,    1'b1, ST_OK,    10'd255,  1'b0, ID_ZERO},
		'{OP_REGISTER,   1'b1, 10'd255,  ID_ALT_5,   1'b1, ST_TAKEN, 10'd255,  1'b0, ID_ZERO},
		'{OP_REGISTER,   1'b1, 10'd256,  ID_ALT_A,   1'b1, ST_MISS,  10'd256,  1'b0, ID_ZERO},
		'{OP_REGISTER,   1'b1, 10'd1023, ID_ONES,    1'b1, ST_MISS,  10'd1023, 1'b0, ID_ZERO},
		// fill ahead of the hint, then allocate: walks past slots 1 and 2
		'{OP_REGISTER,   1'b1, 10'd1,    ID_RAMP_UP, 1'b1, ST_OK,    10'd1,    1'b0, ID_ZERO},
		'{OP_REGISTER,   1'b1, 10'd2,    ID_RAMP_DN, 1'b1, ST_OK,    10'd2,    1'b0, ID_ZERO},
		'{OP_REGISTER,   1'b0, 10'd1023, ID_ALT_A,   1'b1, ST_OK,    10'd3,    1'b0, ID_ZERO},
		'{OP_LOOKUP,     1'b0, 10'd255,  ID_ONES,    1'b1, ST_OK,    10'd255,  1'b1, ID_ZERO},
		// freed slot behind the hint is not reused
		'{OP_UNREGISTER, 1'b1, 10'd1,    ID_ZERO,    1'b1, ST_OK,    10'd1,    1'b0, ID_ZERO},
		'{OP_REGISTER,   1'b0, 10'd0,    ID_ALT_5,   1'b1, ST_OK,    10'd4,    1'b0, ID_ZERO},
		'{OP_LOOKUP,     1'b0, 10'd1,    ID_ZERO,    1'b1, ST_MISS,  10'd1,    1'b0, ID_ZERO},
		'{OP_UNUSED,     1'b1, 10'd2,    ID_ONES,    1'b1, ST_MISS,  10'd2,    1'b0, ID_ZERO},
		'{OP_LOOKUP,     1'b1, 10'd2,    ID_ALT_A,   1'b0, ST_OK,    10'd0,    1'b0, ID_ZERO},
		'{OP_UNREGISTER, 1'b1, 10'd2,    ID_ONES,    1'b0, ST_OK,    10'd0,    1'b0, ID_ZERO},
		'{OP_LOOKUP,     1'b0, 10'd3,    ID_ZERO,    1'b0, ST_OK,    10'd0,    1'b0, ID_ZERO},
		'{OP_REGISTER,   1'b1, 10'd0,    ID_ALT_A,   1'b1, ST_TAKEN, 10'd0,    1'b0, ID_ZERO},
		'{OP_REGISTER,   1'b1, 10'd512,  ID_ALT_5,   1'b1, ST_MISS,  10'd512,  1'b0, ID_ZERO},
		'{OP_UNREGISTER, 1'b0, 10'd700,  ID_ZERO,    1'b1, ST_MISS,  10'd700,  1'b0, ID_ZERO},
		'{OP_LOOKUP,     1'b0, 10'd4,    ID_ZERO,    1'b0, ST_OK,    10'd0,    1'b0, ID_ZERO}
	};

	logic clk = 1'b0;
	logic arst_n;

	srt_req_if #(.ID_WIDTH(ID_WIDTH)) req_ch ();
	srt_rsp_if #(.ID_WIDTH(ID_WIDTH)) rsp_ch ();

	slot_registrar_table #(
		.DEPTH    (DEPTH),
		.ID_WIDTH (ID_WIDTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the slot table
	logic [ID_WIDTH-1:0] shadow_id [DEPTH];
	bit                  shadow_used [DEPTH];
	int                  shadow_hint;

	// Slots that have held an id at some point; most lookups and unregisters pick one of these
	bit                  touched [DEPTH];
	int                  touched_slots [$];

	reply_t due_replies [$];

	int mismatches;
	int replies_seen;
	int cycles;
	int op_count [4];
	int full_count;
	int taken_count;
	int miss_count;
	bit hold_req;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d replies still due", cycles,
				due_replies.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Apply one transaction to the shadow table and return the reply it earns
	function automatic reply_t slot_table_apply(input request_t it);
		reply_t r;
		bit     in_range;
		r.status = ST_MISS;
		r.idx = it.idx;
		r.found = 1'b0;
		r.id = ID_ZERO;
		in_range = it.idx < DEPTH;
		case (it.op)
			OP_REGISTER: begin
				if (it.given) begin
					if (in_range && shadow_used[it.idx]) begin
						r.status = ST_TAKEN;
					end else if (in_range) begin
						shadow_id[it.idx] = it.id;
						shadow_used[it.idx] = 1'b1;
						r.status = ST_OK;
					end
				end else begin
					while (shadow_hint < DEPTH && shadow_used[shadow_hint])
						shadow_hint++;
					if (shadow_hint >= DEPTH) begin
						shadow_hint = DEPTH;
						r.status = ST_FULL;
						r.idx = '0;
					end else begin
						shadow_id[shadow_hint] = it.id;
						shadow_used[shadow_hint] = 1'b1;
						r.status = ST_OK;
						r.idx = IDX_W'(shadow_hint);
						shadow_hint++;
					end
				end
			end
			OP_UNREGISTER: begin
				if (in_range && shadow_used[it.idx]) begin
					shadow_used[it.idx] = 1'b0;
					r.status = ST_OK;
				end
			end
			OP_LOOKUP: begin
				if (in_range && shadow_used[it.idx]) begin
					r.status = ST_OK;
					r.found = 1'b1;
					r.id = shadow_id[it.idx];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Bookkeeping at acceptance: predict, queue the reply, track coverage
	task automatic note_accept(input request_t it, input bit typed, input reply_t want);
		reply_t r;
		r = slot_table_apply(it);
		op_count[it.op]++;
		if (r.status == ST_FULL) full_count++;
		if (r.status == ST_TAKEN) taken_count++;
		if (r.status == ST_MISS) miss_count++;
		if (it.op == OP_REGISTER && r.status == ST_OK && !touched[r.idx]) begin
			touched[r.idx] = 1'b1;
			touched_slots.insert(touched_slots.size(), int'(r.idx));
		end
		due_replies.insert(due_replies.size(), typed ? want : r);
	endtask

	// Present one transaction and hold it until the block takes it
	task automatic offer(input request_t it);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= it.op;
		req_ch.index_given <= it.given;
		req_ch.slot_index <= it.idx;
		req_ch.object_id <= it.id;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	task automatic idle(input int n);
		if (n > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic logic [IDX_W-1:0] pick_touched();
		return IDX_W'(touched_slots[$urandom_range(0, touched_slots.size() - 1)]);
	endfunction

	function automatic logic [IDX_W-1:0] pick_outside();
		return IDX_W'($urandom_range(DEPTH, (1 << IDX_W) - 1));
	endfunction

	// Random transaction; alloc_pct sets the share of allocating registers
	function automatic request_t make_request(input int alloc_pct);
		request_t it;
		int       pick;
		int       sub;
		it.op = OP_REGISTER;
		it.given = 1'($urandom_range(0, 1));
		it.idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
		it.id = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 9);
		if (pick < alloc_pct) begin
			it.given = 1'b0;
		end else if (pick < alloc_pct + 25) begin
			it.given = 1'b1;
			it.idx = (sub == 0) ? pick_outside() : IDX_W'($urandom_range(0, DEPTH - 1));
		end else if (pick < alloc_pct + 45) begin
			it.op = OP_UNREGISTER;
			if (sub < 6 && touched_slots.size() != 0)
				it.idx = pick_touched();
			else if (sub < 9)
				it.idx = IDX_W'($urandom_range(0, DEPTH - 1));
		end else if (pick < 95) begin
			it.op = OP_LOOKUP;
			if (sub < 8 && touched_slots.size() != 0)
				it.idx = pick_touched();
			else
				it.idx = pick_outside();
		end else begin
			it.op = OP_UNUSED;
		end
		return it;
	endfunction

	// Bursts of random length with random gaps; hold_at marks a long receiver stall
	task automatic run_random(input int count, input int alloc_pct, input int hold_at);
		request_t it;
		reply_t   none;
		int       burst;
		int       done;
		none = '0;
		burst = $urandom_range(1, 16);
		done = 0;
		while (done < count) begin
			if (done == hold_at) hold_req = 1'b1;
			it = make_request(alloc_pct);
			offer(it);
			note_accept(it, 1'b0, none);
			done++;
			burst--;
			if (burst == 0) begin
				burst = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
				if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
			end
		end
	endtask

	// Pause the sender until every due reply is back
	task automatic drain();
		idle(1);
		while (due_replies.size() != 0) @(posedge clk);
	endtask

	// Reply checker
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			replies_seen++;
			if (due_replies.size() == 0) begin
				flag_mismatch($sformatf("reply with none due: status %0d index %0d",
					rsp_ch.status, rsp_ch.result_index));
			end else begin
				want = due_replies.pop_front();
				if (rsp_ch.status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d (index %0d)",
						rsp_ch.status, want.status, want.idx));
				if (rsp_ch.result_index !== want.idx)
					flag_mismatch($sformatf("result_index %0d, want %0d",
						rsp_ch.result_index, want.idx));
				if (rsp_ch.found !== want.found)
					flag_mismatch($sformatf("found %0b, want %0b (index %0d)",
						rsp_ch.found, want.found, want.idx));
				if (rsp_ch.result_id !== want.id)
					flag_mismatch($sformatf("result_id %h, want %h (index %0d)",
						rsp_ch.result_id, want.id, want.idx));
			end
		end
	end

	// Receiver: cycles through always-ready, fixed pattern and random stalls
	initial begin
		int phase;
		int hold_left;
		int mode;
		phase = 0;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			mode = (phase / 96) % 4;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= STALL_PAT[phase % 8];
					2: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
			phase++;
		end
	end

	// Main sequence
	initial begin
		request_t it;
		reply_t   want;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_REGISTER;
		req_ch.index_given = 1'b0;
		req_ch.slot_index = '0;
		req_ch.object_id = '0;
		hold_req = 1'b0;
		cycles = 0;
		mismatches = 0;
		replies_seen = 0;
		full_count = 0;
		taken_count = 0;
		miss_count = 0;
		foreach (op_count[k]) op_count[k] = 0;
		foreach (shadow_used[k]) begin
			shadow_used[k] = 1'b0;
			shadow_id[k] = ID_ZERO;
			touched[k] = 1'b0;
		end
		shadow_hint = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (plan[n]) begin
			it.op = plan[n].op;
			it.given = plan[n].given;
			it.idx = plan[n].idx;
			it.id = plan[n].id;
			want.status = plan[n].w_status;
			want.idx = plan[n].w_idx;
			want.found = plan[n].w_found;
			want.id = plan[n].w_id;
			offer(it);
			note_accept(it, plan[n].typed, want);
			if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 4));
		end

		// balanced mix, then an allocation-heavy run with a long receiver stall, then balanced again
		run_random(350, 20, -1);
		drain();
		run_random(300, 50, 120);
		run_random(250, 20, -1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d transactions: %0d register, %0d unregister, %0d lookup, %0d unused",
			op_count[0] + op_count[1] + op_count[2] + op_count[3],
			op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("Checked %0d replies (%0d table full, %0d taken, %0d miss), hint at %0d",
			replies_seen, full_count, taken_count, miss_count, shadow_hint);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
sv/srt_pkg.sv
sv/srt_req_if.sv
sv/srt_rsp_if.sv
sv/srt_ram.sv
sv/srt_ctrl.sv
sv/slot_registrar_table.sv
bench/slot_registrar_table_tb.sv
